>>> src/scf_pkg.sv
package scf_pkg;

	localparam logic [7:0]  FRAME_TAG = 8'h5A;
	localparam logic [15:0] CRC_POLY  = 16'hA001;
	localparam logic [15:0] CRC_INIT  = 16'hFFFF;
	localparam logic [7:0]  LEN_BASE  = 8'd5;
	localparam logic [7:0]  CNT_MAX   = 8'hFF;

	localparam int unsigned N_PHASE = 7;

	typedef logic [2:0] phase_t;

	localparam phase_t PH_TAG   = 3'd0;
	localparam phase_t PH_LEN   = 3'd1;
	localparam phase_t PH_CMD   = 3'd2;
	localparam phase_t PH_PARAM = 3'd3;
	localparam phase_t PH_DATA  = 3'd4;
	localparam phase_t PH_CRCH  = 3'd5;
	localparam phase_t PH_CRCL  = 3'd6;

	typedef struct packed {
		logic       frame_start;
		logic       frame_end;
		logic       byte_present;
		logic [7:0] payload_byte;
		logic [7:0] command_code;
		logic       param_present;
		logic [7:0] param_value;
		logic [7:0] payload_length;
	} cmd_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       frame_done;
		logic       length_error;
	} frame_item_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

>>> src/scf_if.sv
interface scf_cmd_if import scf_pkg::*; ();
	logic      valid;
	logic      ready;
	cmd_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface scf_frame_if import scf_pkg::*; ();
	logic        valid;
	logic        ready;
	frame_item_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

>>> src/serial_command_framer_crc16.sv
// channel    dir  word                                   handshake
// cmd_in     in   cmd_item_t: start/end/byte/cmd/param   valid & ready
// frame_out  out  frame_item_t: byte and frame flags     valid & ready
//
// One output byte per cycle while frame_out is ready. An item holds the
// input until it has yielded its bytes: a plain payload item streams at
// that rate; a start or end item holds it for its header or CRC bytes.
// The rate is set by the single output register and the one-byte CRC step.
// Reset clears the frame state, the item valid flag and the output valid.
// A stalled output holds its word; the next byte waits in the item register.
module serial_command_framer_crc16 import scf_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	scf_cmd_if.sink      cmd_in,
	scf_frame_if.source  frame_out
);

	logic        item_v_q;
	cmd_item_t   item_q;
	phase_t      phase_q;
	logic [15:0] crc_q;
	logic        frame_open_q;
	logic [7:0]  bytes_seen_q;
	logic [7:0]  bytes_expected_q;
	logic        out_v_q;
	frame_item_t out_q;

	logic               open_eff;
	logic [N_PHASE-1:0] en;
	logic [N_PHASE-1:0] avail;
	phase_t             sel;
	logic               found;
	logic               more;
	logic               out_free;
	logic               emit;
	logic               done_now;
	logic [7:0]         cur_byte;
	logic [7:0]         len_byte;

	assign open_eff = frame_open_q | item_q.frame_start;
	assign len_byte = item_q.payload_length + LEN_BASE + {7'd0, item_q.param_present};

	always_comb begin
		en[PH_TAG]   = item_q.frame_start;
		en[PH_LEN]   = item_q.frame_start;
		en[PH_CMD]   = item_q.frame_start;
		en[PH_PARAM] = item_q.frame_start & item_q.param_present;
		en[PH_DATA]  = item_q.byte_present & open_eff;
		en[PH_CRCH]  = item_q.frame_end & open_eff;
		en[PH_CRCL]  = item_q.frame_end & open_eff;
	end

	always_comb begin
		sel   = PH_TAG;
		found = 1'b0;
		more  = 1'b0;
		for (int k = 0; k < N_PHASE; k++) begin
			avail[k] = item_v_q & en[k] & (phase_t'(k) >= phase_q);
			if (avail[k]) begin
				if (found) begin
					more = 1'b1;
				end else begin
					sel   = phase_t'(k);
					found = 1'b1;
				end
			end
		end
	end

	always_comb begin
		unique case (sel)
			PH_TAG:   cur_byte = FRAME_TAG;
			PH_LEN:   cur_byte = len_byte;
			PH_CMD:   cur_byte = item_q.command_code;
			PH_PARAM: cur_byte = item_q.param_value;
			PH_DATA:  cur_byte = item_q.payload_byte;
			PH_CRCH:  cur_byte = crc_q[15:8];
			PH_CRCL:  cur_byte = crc_q[7:0];
			default:  cur_byte = item_q.payload_byte;
		endcase
	end

	assign out_free     = ~out_v_q | frame_out.ready;
	assign emit         = found & out_free;
	assign done_now     = item_v_q & (~found | (emit & ~more));
	assign cmd_in.ready = ~item_v_q | done_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_v_q <= 1'b0;
			phase_q  <= PH_TAG;
		end else begin
			if (cmd_in.valid && cmd_in.ready) begin
				item_v_q <= 1'b1;
				phase_q  <= PH_TAG;
			end else if (done_now) begin
				item_v_q <= 1'b0;
				phase_q  <= PH_TAG;
			end else if (emit) begin
				phase_q <= sel + phase_t'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_in.valid && cmd_in.ready) begin
			item_q <= cmd_in.payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q            <= CRC_INIT;
			frame_open_q     <= 1'b0;
			bytes_seen_q     <= '0;
			bytes_expected_q <= '0;
		end else if (emit) begin
			unique case (sel)
				PH_TAG: begin
					crc_q            <= crc_feed(CRC_INIT, FRAME_TAG);
					frame_open_q     <= 1'b1;
					bytes_seen_q     <= '0;
					bytes_expected_q <= item_q.payload_length;
				end
				PH_LEN, PH_CMD, PH_PARAM: begin
					crc_q <= crc_feed(crc_q, cur_byte);
				end
				PH_DATA: begin
					crc_q <= crc_feed(crc_q, cur_byte);
					if (bytes_seen_q != CNT_MAX) begin
						bytes_seen_q <= bytes_seen_q + 8'd1;
					end
				end
				PH_CRCH: begin
				end
				PH_CRCL: begin
					crc_q        <= CRC_INIT;
					frame_open_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_free) begin
			out_v_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.out_byte     <= cur_byte;
			out_q.run_last     <= ~more;
			out_q.frame_done   <= (sel == PH_CRCL);
			out_q.length_error <= (sel == PH_CRCL) && (bytes_seen_q != bytes_expected_q);
		end
	end

	assign frame_out.valid   = out_v_q;
	assign frame_out.payload = out_q;

	a_done_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.frame_done |-> out_q.run_last)
		else $error("frame_done without run_last");

	a_err_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.length_error |-> out_q.frame_done)
		else $error("length_error outside frame end");

	a_close_resets: assert property (@(posedge clk) disable iff (!arst_n)
		emit && sel == PH_CRCL |=> crc_q == CRC_INIT && !frame_open_q)
		else $error("frame not closed after CRC");

	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!item_v_q |-> cmd_in.ready)
		else $error("input stalled with empty item register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !frame_out.ready |=> out_v_q && $stable(out_q))
		else $error("output word lost under stall");

endmodule

>>> test/tb.sv
`timescale 1ns / 100ps

module tb;
	import scf_pkg::*;

	localparam int LIMIT = 400000;
	localparam int ITEM_TARGET = 300;
	localparam int DRILL_N = 22;
	localparam int TYPED_N = 26;
	localparam int NO_TYPED = -1;
	localparam int PRESSURE_AT = 40;
	localparam int PRESSURE_CYCLES = 300;

	// start, end, byte, payload_byte, command, param, param_value, length
	localparam cmd_item_t DRILL [DRILL_N] = '{
		'{1'b0, 1'b0, 1'b1, 8'hFF, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b1, 1'b1, 8'h00, 8'hFF, 1'b1, 8'hFF, 8'd255},
		'{1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b1, 1'b0, 1'b0, 8'h00, 8'hFF, 1'b1, 8'hFF, 8'd249},
		'{1'b0, 1'b0, 1'b1, 8'hFF, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b0, 1'b1, 8'h00, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b1, 1'b0, 1'b0, 8'h00, 8'hA5, 1'b0, 8'h00, 8'd255},
		'{1'b1, 1'b0, 1'b1, 8'h3C, 8'hC3, 1'b1, 8'h81, 8'd1},
		'{1'b0, 1'b1, 1'b1, 8'h7E, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b1, 1'b1, 1'b1, 8'hAA, 8'h55, 1'b1, 8'h01, 8'd1},
		'{1'b1, 1'b1, 1'b0, 8'h00, 8'h12, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b0, 1'b0, 8'hFF, 8'hFF, 1'b1, 8'hFF, 8'd255},
		'{1'b1, 1'b0, 1'b0, 8'h00, 8'h01, 1'b0, 8'h00, 8'd3},
		'{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b0, 1'b1, 8'h80, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b0, 1'b1, 8'h01, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b1, 1'b1, 8'hFE, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'd0},
		'{1'b1, 1'b0, 1'b1, 8'h55, 8'h7F, 1'b0, 8'h00, 8'd250},
		'{1'b0, 1'b1, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 8'd0}
	};

	localparam int DRILL_TYPED [DRILL_N] = '{
		0, 0, 3, NO_TYPED, 4, 1, 1, NO_TYPED, 3, 5, NO_TYPED,
		NO_TYPED, NO_TYPED, 0, 3, 0, 1, 1, NO_TYPED, 0, 4, NO_TYPED
	};

	// out_byte, run_last, frame_done, length_error
	localparam frame_item_t TYPED_WORDS [TYPED_N] = '{
		'{8'h5A, 1'b0, 1'b0, 1'b0}, '{8'h05, 1'b0, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0},
		'{8'hFF, 1'b1, 1'b0, 1'b0},
		'{8'hFF, 1'b1, 1'b0, 1'b0},
		'{8'h00, 1'b1, 1'b0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 1'b0}, '{8'h04, 1'b0, 1'b0, 1'b0}, '{8'hA5, 1'b1, 1'b0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 1'b0}, '{8'h07, 1'b0, 1'b0, 1'b0}, '{8'hC3, 1'b0, 1'b0, 1'b0},
		'{8'h81, 1'b0, 1'b0, 1'b0}, '{8'h3C, 1'b1, 1'b0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 1'b0}, '{8'h08, 1'b0, 1'b0, 1'b0}, '{8'h01, 1'b1, 1'b0, 1'b0},
		'{8'h80, 1'b1, 1'b0, 1'b0},
		'{8'h01, 1'b1, 1'b0, 1'b0},
		'{8'h5A, 1'b0, 1'b0, 1'b0}, '{8'hFF, 1'b0, 1'b0, 1'b0}, '{8'h7F, 1'b0, 1'b0, 1'b0},
		'{8'h55, 1'b1, 1'b0, 1'b0}
	};

	logic clk;
	logic arst_n;

	scf_cmd_if   cmd_bus ();
	scf_frame_if frame_bus ();

	serial_command_framer_crc16 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_in    (cmd_bus),
		.frame_out (frame_bus)
	);

	frame_item_t expected_frame_bytes [$];
	frame_item_t item_bytes [$];
	logic [15:0] crc_run = CRC_INIT;
	logic        in_frame = 1'b0;
	logic [7:0]  payload_count = '0;
	logic [7:0]  announced_len = '0;
	int          mismatches = 0;
	int          sent_items = 0;
	bit          calm_tx = 1'b0;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic int draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic cmd_item_t random_word();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(cmd_item_t)-1:0];
	endfunction

	function automatic void put_framed(logic [7:0] b);
		logic [15:0] r;
		item_bytes.push_back('{b, 1'b0, 1'b0, 1'b0});
		r = crc_run;
		for (int i = 0; i < 8; i++) begin
			if (r[0] ^ b[i]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		crc_run = r;
	endfunction

	function automatic void predict_framing(cmd_item_t w);
		logic [7:0] lenb;
		item_bytes.delete();
		if (w.frame_start) begin
			lenb = w.payload_length + LEN_BASE + {7'd0, w.param_present};
			crc_run = CRC_INIT;
			in_frame = 1'b1;
			payload_count = '0;
			announced_len = w.payload_length;
			put_framed(FRAME_TAG);
			put_framed(lenb);
			put_framed(w.command_code);
			if (w.param_present) begin
				put_framed(w.param_value);
			end
		end
		if (w.byte_present && in_frame) begin
			put_framed(w.payload_byte);
			if (payload_count != CNT_MAX) begin
				payload_count++;
			end
		end
		if (w.frame_end && in_frame) begin
			item_bytes.push_back('{crc_run[15:8], 1'b0, 1'b0, 1'b0});
			item_bytes.push_back('{crc_run[7:0], 1'b0, 1'b1, payload_count != announced_len});
			in_frame = 1'b0;
			crc_run = CRC_INIT;
		end
		if (item_bytes.size() != 0) begin
			item_bytes[item_bytes.size() - 1].run_last = 1'b1;
		end
	endfunction

	task automatic flag_mismatch(string what, logic [7:0] got, logic [7:0] want);
		mismatches++;
		$display("%0t: %s got %h, want %h", $time, what, got, want);
	endtask

	task automatic send_word(cmd_item_t w, int typed_n, int typed_at);
		int gap;
		gap = draw_wait(calm_tx);
		if ($urandom_range(0, 15) == 0) begin
			calm_tx = !calm_tx;
		end
		repeat (gap) begin
			@(negedge clk);
			cmd_bus.valid <= 1'b0;
		end
		@(negedge clk);
		cmd_bus.valid <= 1'b1;
		cmd_bus.payload <= w;
		do @(posedge clk); while (cmd_bus.ready !== 1'b1);
		predict_framing(w);
		sent_items++;
		if (typed_n == NO_TYPED) begin
			foreach (item_bytes[k]) expected_frame_bytes.push_back(item_bytes[k]);
		end else begin
			for (int k = 0; k < typed_n; k++) begin
				expected_frame_bytes.push_back(TYPED_WORDS[typed_at + k]);
			end
		end
	endtask

	task automatic send_random_frame();
		cmd_item_t w;
		int r;
		int plen;
		int left;
		bit close;
		r = $urandom_range(0, 19);
		if (r < 15) begin
			plen = $urandom_range(0, 6);
		end else if (r < 18) begin
			plen = $urandom_range(7, 249);
		end else begin
			plen = $urandom_range(250, 255);
		end
		if ($urandom_range(0, 3) == 0 || plen > 12) begin
			left = $urandom_range(0, 8);
		end else begin
			left = plen;
		end
		close = ($urandom_range(0, 7) != 0);

		w = random_word();
		w.frame_start = 1'b1;
		w.frame_end = 1'b0;
		w.payload_length = plen[7:0];
		w.byte_present = (left > 0) && ($urandom_range(0, 2) == 0);
		if (w.byte_present) begin
			left--;
		end
		if (close && left == 0 && $urandom_range(0, 2) == 0) begin
			w.frame_end = 1'b1;
			close = 1'b0;
		end
		send_word(w, NO_TYPED, 0);

		while (left > 0) begin
			w = random_word();
			w.frame_start = 1'b0;
			w.frame_end = 1'b0;
			w.byte_present = 1'b1;
			if ($urandom_range(0, 9) == 0) begin
				w.byte_present = 1'b0;
			end else begin
				left--;
			end
			if (close && left == 0 && $urandom_range(0, 1) == 0) begin
				w.frame_end = 1'b1;
				close = 1'b0;
			end
			send_word(w, NO_TYPED, 0);
		end

		if (close) begin
			w = random_word();
			w.frame_start = 1'b0;
			w.frame_end = 1'b1;
			w.byte_present = 1'b0;
			send_word(w, NO_TYPED, 0);
		end
	endtask

	initial begin
		cmd_item_t w;
		int typed_at;
		arst_n = 1'b0;
		cmd_bus.valid = 1'b0;
		cmd_bus.payload = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		typed_at = 0;
		for (int i = 0; i < DRILL_N; i++) begin
			send_word(DRILL[i], DRILL_TYPED[i], typed_at);
			if (DRILL_TYPED[i] > 0) begin
				typed_at += DRILL_TYPED[i];
			end
		end

		// overrun the count past its ceiling
		w = '0;
		w.frame_start = 1'b1;
		w.payload_length = CNT_MAX;
		w.command_code = 8'($urandom_range(0, 255));
		send_word(w, NO_TYPED, 0);
		repeat (257) begin
			w = random_word();
			w.frame_start = 1'b0;
			w.frame_end = 1'b0;
			w.byte_present = 1'b1;
			send_word(w, NO_TYPED, 0);
		end
		w = '0;
		w.frame_end = 1'b1;
		send_word(w, NO_TYPED, 0);

		while (sent_items < ITEM_TARGET) begin
			if ($urandom_range(0, 9) == 0) begin
				send_word(random_word(), NO_TYPED, 0);
			end else begin
				send_random_frame();
			end
		end
		@(negedge clk);
		cmd_bus.valid <= 1'b0;

		while (expected_frame_bytes.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[serial_command_framer_crc16] OK");
		end else begin
			$display("[serial_command_framer_crc16] ERROR");
		end
		$finish;
	end

	initial begin
		frame_item_t want;
		frame_item_t got;
		int hold;
		int taken;
		bit calm_rx;
		bit pressed;
		frame_bus.ready = 1'b0;
		taken = 0;
		calm_rx = 1'b0;
		pressed = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			hold = draw_wait(calm_rx);
			if ($urandom_range(0, 15) == 0) begin
				calm_rx = !calm_rx;
			end
			// hold off long enough to back up the input
			if (!pressed && taken == PRESSURE_AT) begin
				hold = PRESSURE_CYCLES;
				pressed = 1'b1;
			end
			repeat (hold) begin
				@(negedge clk);
				frame_bus.ready <= 1'b0;
			end
			@(negedge clk);
			frame_bus.ready <= 1'b1;
			do @(posedge clk); while (frame_bus.valid !== 1'b1);
			taken++;
			got = frame_bus.payload;
			if (expected_frame_bytes.size() == 0) begin
				flag_mismatch("unexpected word, out_byte", got.out_byte, 8'h00);
			end else begin
				want = expected_frame_bytes.pop_front();
				if (got.out_byte !== want.out_byte) begin
					flag_mismatch("out_byte", got.out_byte, want.out_byte);
				end
				if (got.run_last !== want.run_last) begin
					flag_mismatch("run_last", {7'd0, got.run_last}, {7'd0, want.run_last});
				end
				if (got.frame_done !== want.frame_done) begin
					flag_mismatch("frame_done", {7'd0, got.frame_done}, {7'd0, want.frame_done});
				end
				if (got.length_error !== want.length_error) begin
					flag_mismatch("length_error", {7'd0, got.length_error},
						{7'd0, want.length_error});
				end
			end
		end
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("[serial_command_framer_crc16] ERROR");
		$finish;
	end

endmodule
